// ===== rtl/core/sts_pkg.sv =====
`timescale 1ns / 1ps

package sts_pkg;

    localparam int NUM_PRIORITIES_DEF = 32;
    localparam int NUM_SIGNALS_DEF    = 64;

    localparam int OP_W       = 2;
    localparam int SIGNAL_W   = 6;
    localparam int PRIO_W     = 6;
    localparam int KIND_W     = 2;
    localparam int SUB_W      = 6;
    localparam int LIMIT_W    = 7;
    localparam int FIRST_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Priority counter runs from the number of priorities (at most 64) down to 1.
    localparam int PCNT_W = 7;

    localparam logic [OP_W-1:0] OP_PUBLISH     = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SUBSCRIBE   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_UNSUBSCRIBE = OP_W'(2);
    localparam logic [OP_W-1:0] OP_UNSUB_ALL   = OP_W'(3);

    localparam logic [KIND_W-1:0] KIND_DELIVER = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_NONE    = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_DONE    = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_ERROR   = KIND_W'(3);

    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_USER   = CFG_IDX_W'(1);

    localparam logic [LIMIT_W-1:0] SIGNAL_LIMIT_RST = LIMIT_W'(64);
    localparam logic [FIRST_W-1:0] FIRST_USER_RST   = FIRST_W'(4);

endpackage

// ===== rtl/core/sts_if.sv =====
`timescale 1ns / 1ps

interface sts_cmd_if import sts_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SIGNAL_W-1:0] signal;
    logic [PRIO_W-1:0]   priority_req;

    modport source (output valid, output op, output signal, output priority_req, input ready);
    modport sink   (input valid, input op, input signal, input priority_req, output ready);
endinterface

interface sts_res_if import sts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SUB_W-1:0]  subscriber;
    logic              last;

    modport source (output valid, output kind, output subscriber, output last, input ready);
    modport sink   (input valid, input kind, input subscriber, input last, output ready);
endinterface

interface sts_cfg_if import sts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/sts_table.sv =====
`timescale 1ns / 1ps

module sts_table
    import sts_pkg::*;
#(
    parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
    parameter int NUM_SIGNALS    = NUM_SIGNALS_DEF,
    localparam int SIG_W         = $clog2(NUM_SIGNALS)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [SIG_W-1:0]          waddr,
    input  logic [NUM_PRIORITIES-1:0] wdata,
    input  logic [SIG_W-1:0]          raddr,
    output logic [NUM_PRIORITIES-1:0] rdata
);

    logic [NUM_PRIORITIES-1:0] mem [NUM_SIGNALS];
    logic [NUM_PRIORITIES-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/subscription_table_multicast_top.sv =====
`timescale 1ns / 1ps
// Publish: the mask is fetched from the table, then the priorities are scanned from the highest
// down to the lowest subscribed one, one result per set bit; a full output register holds it.
// Subscribe and unsubscribe: read, write, result. Unsubscribe-all walks the table entries from
// the first user signal up to the limit, then gives its result. One request at a time; the next
// one is taken once the last result is in the output register. After reset a clearing pass zeroes
// the table with command ready held low; the limit and first user signal registers return to 64 and 4.

module subscription_table_multicast_top
    import sts_pkg::*;
#(
    parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
    parameter int NUM_SIGNALS    = NUM_SIGNALS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sts_cmd_if.sink   cmd,
    sts_res_if.source res,
    sts_cfg_if.sink   cfg
);

    localparam int SIG_W = $clog2(NUM_SIGNALS);
    localparam int CNT_W = ($clog2(NUM_SIGNALS + 1) > LIMIT_W) ? $clog2(NUM_SIGNALS + 1)
                                                               : LIMIT_W;
    localparam int NP    = NUM_PRIORITIES;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUB_WAIT,
        ST_SUB_WAIT,
        ST_ALL_WAIT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [SIG_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]    cursor_reg, cursor_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [NP-1:0]       bit_reg, bit_next;
    logic [NP-1:0]       pend_reg, pend_next;
    logic [PCNT_W-1:0]   p_reg, p_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [FIRST_W-1:0]  first_reg, first_next;

    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [SUB_W-1:0]    out_sub_reg, out_sub_next;
    logic                out_last_reg, out_last_next;

    logic                tbl_we;
    logic [SIG_W-1:0]    tbl_waddr;
    logic [NP-1:0]       tbl_wdata;
    logic [CNT_W-1:0]    raddr_full;
    logic [NP-1:0]       tbl_rdata;

    logic [CNT_W-1:0]    lim;
    logic [CNT_W-1:0]    sig_ext;
    logic [CNT_W-1:0]    first_ext;
    logic [CNT_W-1:0]    cursor_inc;
    logic [PRIO_W-1:0]   prio_idx;
    logic                prio_ok;
    logic                cmd_acc;
    logic                can_emit;
    logic [NP-1:0]       pend_shl;

    sts_table #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .NUM_SIGNALS    (NUM_SIGNALS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (raddr_full[SIG_W-1:0]),
        .rdata (tbl_rdata)
    );

    assign lim        = (CNT_W'(limit_reg) < CNT_W'(NUM_SIGNALS)) ? CNT_W'(limit_reg)
                                                                  : CNT_W'(NUM_SIGNALS);
    assign sig_ext    = CNT_W'(cmd.signal);
    assign first_ext  = CNT_W'(first_reg);
    assign cursor_inc = cursor_reg + CNT_W'(1);
    assign prio_idx   = cmd.priority_req - PRIO_W'(1);
    assign prio_ok    = (cmd.priority_req != '0)
                        && ({1'b0, cmd.priority_req} <= (PRIO_W + 1)'(NUM_PRIORITIES));
    assign cmd_acc    = cmd.valid && cmd.ready;
    assign can_emit   = !out_valid_reg || res.ready;
    assign pend_shl   = pend_reg << 1;

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign res.valid      = out_valid_reg;
    assign res.kind       = out_kind_reg;
    assign res.subscriber = out_sub_reg;
    assign res.last       = out_last_reg;

    // Table port: the clearing pass and the read-modify-write steps share the one write port.
    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = cursor_reg[SIG_W-1:0];
        tbl_wdata = tbl_rdata & ~bit_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = '0;
            end
            ST_SUB_WAIT:
            begin
                tbl_we = 1'b1;
                if (op_reg == OP_SUBSCRIBE)
                begin
                    tbl_wdata = tbl_rdata | bit_reg;
                end
            end
            ST_ALL_WAIT:
            begin
                tbl_we = 1'b1;
            end
            default:
            begin
                tbl_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_ALL_WAIT)
        begin
            raddr_full = cursor_inc;
        end
        else if (cmd.op == OP_UNSUB_ALL)
        begin
            raddr_full = first_ext;
        end
        else
        begin
            raddr_full = sig_ext;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cursor_next    = cursor_reg;
        op_next        = op_reg;
        bit_next       = bit_reg;
        pend_next      = pend_reg;
        p_next         = p_reg;
        kind_next      = kind_reg;
        limit_next     = limit_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        out_sub_next   = out_sub_reg;
        out_last_next  = out_last_reg;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SIGNAL_LIMIT: limit_next = cfg.data[LIMIT_W-1:0];
                REG_FIRST_USER:   first_next = cfg.data[FIRST_W-1:0];
                default:          limit_next = limit_reg;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + SIG_W'(1);
                if (clr_reg == SIG_W'(NUM_SIGNALS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    op_next     = cmd.op;
                    bit_next    = NP'(1) << prio_idx;
                    cursor_next = raddr_full;
                    state_next  = ST_EMIT;
                    kind_next   = KIND_ERROR;
                    if (cmd.op == OP_PUBLISH)
                    begin
                        if (sig_ext < lim)
                        begin
                            state_next = ST_PUB_WAIT;
                        end
                    end
                    else if (prio_ok)
                    begin
                        if (cmd.op == OP_UNSUB_ALL)
                        begin
                            if (first_ext < lim)
                            begin
                                state_next = ST_ALL_WAIT;
                            end
                            else
                            begin
                                kind_next = KIND_DONE;
                            end
                        end
                        else if (sig_ext >= first_ext && sig_ext < lim)
                        begin
                            state_next = ST_SUB_WAIT;
                        end
                    end
                end
            end

            ST_PUB_WAIT:
            begin
                if (tbl_rdata == '0)
                begin
                    kind_next  = KIND_NONE;
                    state_next = ST_EMIT;
                end
                else
                begin
                    pend_next  = tbl_rdata;
                    p_next     = PCNT_W'(NUM_PRIORITIES);
                    state_next = ST_SCAN;
                end
            end

            ST_SUB_WAIT:
            begin
                kind_next  = KIND_DONE;
                state_next = ST_EMIT;
            end

            ST_ALL_WAIT:
            begin
                cursor_next = cursor_inc;
                if (cursor_inc >= lim)
                begin
                    kind_next  = KIND_DONE;
                    state_next = ST_EMIT;
                end
            end

            ST_SCAN:
            begin
                // The pending mask shifts up one place a cycle unless a full output register holds a delivery;
                // its top bit is the priority in the counter.
                if (!pend_reg[NP-1])
                begin
                    pend_next = pend_shl;
                    p_next    = p_reg - PCNT_W'(1);
                end
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_DELIVER;
                    out_sub_next   = p_reg[SUB_W-1:0];
                    out_last_next  = (pend_shl == '0);
                    pend_next      = pend_shl;
                    p_next         = p_reg - PCNT_W'(1);
                    if (pend_shl == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    out_sub_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cursor_reg    <= '0;
            op_reg        <= OP_PUBLISH;
            bit_reg       <= '0;
            pend_reg      <= '0;
            p_reg         <= '0;
            kind_reg      <= KIND_DONE;
            limit_reg     <= SIGNAL_LIMIT_RST;
            first_reg     <= FIRST_USER_RST;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_DONE;
            out_sub_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cursor_reg    <= cursor_next;
            op_reg        <= op_next;
            bit_reg       <= bit_next;
            pend_reg      <= pend_next;
            p_reg         <= p_next;
            kind_reg      <= kind_next;
            limit_reg     <= limit_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_sub_reg   <= out_sub_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Only deliveries carry a subscriber; every other result closes its request.
    a_nondeliver_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg != KIND_DELIVER |-> out_last_reg && out_sub_reg == '0)
        else $error("non-delivery result without last or with a subscriber");

    // The scan is only entered with subscribers left and stops at the last one.
    a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> pend_reg != '0)
        else $error("priority scan running on an empty pending mask");

    // The table is never written in the cycle a new request is taken.
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |-> !tbl_we)
        else $error("table write while accepting a request");

    // A delivery is followed by another delivery unless it was marked last.
    a_delivery_chain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && pend_reg[NP-1] && can_emit && pend_shl != '0
        |=> state_reg == ST_SCAN)
        else $error("publish scan left before its final delivery");

endmodule
